// File: rtl/jdb_pkg.sv
// ----------------------------------------------------------------------------
// jdb_pkg
// Types and constants shared by the joystick direction and button debounce unit.
// ----------------------------------------------------------------------------
package jdb_pkg;

	localparam int SAMPLE_BITS   = 10;
	localparam int SAMPLE_W      = 10;
	localparam int TICK_W        = 8;
	localparam int LEVEL_W       = 3;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

	localparam logic [TICK_W-1:0]  DEBOUNCE_RESET = 8'd8;
	localparam logic [TICK_W-1:0]  TICK_MAX       = 8'hFF;
	localparam logic [LEVEL_W-1:0] LEVEL_MIN      = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 3'd7;

	typedef enum logic [1:0] {
		MODE_IDLE       = 2'd0,
		MODE_PRESS_DB   = 2'd1,
		MODE_HELD       = 2'd2,
		MODE_RELEASE_DB = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_MIN  = 2'd1,
		DIR_MAX  = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		EV_Y_MAX = 3'd0,
		EV_Y_MIN = 3'd1,
		EV_X_MAX = 3'd2,
		EV_X_MIN = 3'd3,
		EV_PRESS = 3'd4
	} event_t;

	typedef struct packed {
		logic                tick;
		logic                sample_valid;
		logic [SAMPLE_W-1:0] x_sample;
		logic [SAMPLE_W-1:0] y_sample;
		logic                button_level;
	} in_item_t;

	typedef struct packed {
		logic [1:0] count;
		event_t     code0;
		event_t     code1;
	} result_t;

	typedef struct packed {
		event_t code;
		logic   last;
	} out_item_t;

	function automatic logic [LEVEL_W-1:0] quantize(input logic [SAMPLE_W-1:0] s);
		return s[SAMPLE_BITS-1 -: LEVEL_W];
	endfunction

endpackage

// File: rtl/jdb_in_if.sv
// ----------------------------------------------------------------------------
// jdb_in_if
// Poll channel: tick, sample pair and button level.
// ----------------------------------------------------------------------------
interface jdb_in_if
	import jdb_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                tick;
	logic                sample_valid;
	logic [SAMPLE_W-1:0] x_sample;
	logic [SAMPLE_W-1:0] y_sample;
	logic                button_level;

	modport source (output valid, tick, sample_valid, x_sample, y_sample, button_level,
		input ready);
	modport sink (input valid, tick, sample_valid, x_sample, y_sample, button_level,
		output ready);
endinterface

// File: rtl/jdb_out_if.sv
// ----------------------------------------------------------------------------
// jdb_out_if
// Event channel: event code and last flag.
// ----------------------------------------------------------------------------
interface jdb_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_code;
	logic       last;

	modport source (output valid, event_code, last, input ready);
	modport sink (input valid, event_code, last, output ready);
endinterface

// File: rtl/jdb_cfg_if.sv
// ----------------------------------------------------------------------------
// jdb_cfg_if
// Configuration write channel for the debounce tick count.
// ----------------------------------------------------------------------------
interface jdb_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/jdb_core.sv
// ----------------------------------------------------------------------------
// jdb_core
// Mode, tick counter and axis latches; evaluates one registered poll.
// ----------------------------------------------------------------------------
module jdb_core
	import jdb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  in_item_t          item,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_data,
	output result_t           result
);

	mode_t             mode_q, mode_d;
	dir_t              x_dir_q, x_dir_d, y_dir_q, y_dir_d;
	logic [TICK_W-1:0] tick_count_q, tick_count_d, tick_inc;
	logic [TICK_W-1:0] debounce_q;
	logic [LEVEL_W-1:0] x_lvl, y_lvl;
	logic              pressed, done;
	logic              x_ev, y_ev;
	event_t            x_code, y_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			tick_count_q <= '0;
			x_dir_q      <= DIR_NONE;
			y_dir_q      <= DIR_NONE;
		end else if (fire) begin
			mode_q       <= mode_d;
			tick_count_q <= tick_count_d;
			x_dir_q      <= x_dir_d;
			y_dir_q      <= y_dir_d;
		end
	end

	always_comb begin
		pressed  = !item.button_level;
		tick_inc = (item.tick && tick_count_q != TICK_MAX) ? tick_count_q + 1'b1 : tick_count_q;
		done     = tick_inc >= debounce_q;
		x_lvl    = quantize(item.x_sample);
		y_lvl    = quantize(item.y_sample);

		x_dir_d = x_dir_q;
		x_ev    = 1'b0;
		x_code  = EV_X_MIN;
		if (x_lvl == LEVEL_MIN) begin
			x_ev    = x_dir_q != DIR_MIN;
			x_dir_d = DIR_MIN;
		end else if (x_lvl == LEVEL_MAX) begin
			x_ev    = x_dir_q != DIR_MAX;
			x_dir_d = DIR_MAX;
			x_code  = EV_X_MAX;
		end else begin
			x_dir_d = DIR_NONE;
		end

		y_dir_d = y_dir_q;
		y_ev    = 1'b0;
		y_code  = EV_Y_MIN;
		if (y_lvl == LEVEL_MIN) begin
			y_ev    = y_dir_q != DIR_MIN;
			y_dir_d = DIR_MIN;
		end else if (y_lvl == LEVEL_MAX) begin
			y_ev    = y_dir_q != DIR_MAX;
			y_dir_d = DIR_MAX;
			y_code  = EV_Y_MAX;
		end else begin
			y_dir_d = DIR_NONE;
		end

		mode_d       = mode_q;
		tick_count_d = tick_inc;
		result.count = 2'd0;
		result.code0 = x_code;
		result.code1 = y_code;

		unique case (mode_q)
			MODE_IDLE: begin
				if (!item.sample_valid || pressed) begin
					x_dir_d = x_dir_q;
					y_dir_d = y_dir_q;
				end
				if (item.sample_valid) begin
					if (pressed) begin
						tick_count_d = '0;
						mode_d       = MODE_PRESS_DB;
					end else begin
						result.count = {1'b0, x_ev} + {1'b0, y_ev};
						if (!x_ev) begin
							result.code0 = y_code;
						end
					end
				end
			end
			MODE_PRESS_DB: begin
				x_dir_d = x_dir_q;
				y_dir_d = y_dir_q;
				if (done) begin
					if (pressed) begin
						result.count = 2'd1;
						result.code0 = EV_PRESS;
						mode_d       = MODE_HELD;
					end else begin
						mode_d = MODE_IDLE;
					end
				end
			end
			MODE_HELD: begin
				x_dir_d = x_dir_q;
				y_dir_d = y_dir_q;
				if (!pressed) begin
					tick_count_d = '0;
					mode_d       = MODE_RELEASE_DB;
				end
			end
			MODE_RELEASE_DB: begin
				x_dir_d = x_dir_q;
				y_dir_d = y_dir_q;
				if (done) begin
					mode_d = pressed ? MODE_HELD : MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/jdb_fifo.sv
// ----------------------------------------------------------------------------
// jdb_fifo
// Event queue: takes up to two events a cycle, hands out one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module jdb_fifo
	import jdb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  result_t   result,
	output logic      space2,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	out_item_t            mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q, rd_q, wr_next;
	logic [FIFO_CW-1:0]   count_q, n_push;
	logic                 pop;

	assign n_push    = push ? FIFO_CW'(result.count) : '0;
	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign space2    = count_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign out_item  = mem[rd_q];
	assign wr_next   = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push && result.count != 2'd0) begin
			mem[wr_q] <= '{code: result.code0, last: result.count == 2'd1};
		end
		if (push && result.count == 2'd2) begin
			mem[wr_next] <= '{code: result.code1, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[FIFO_AW-1:0];
			rd_q    <= rd_q + FIFO_AW'(pop);
			count_q <= count_q + n_push - FIFO_CW'(pop);
		end
	end

endmodule

// File: rtl/joystick_direction_and_button_debounce_unit.sv
// ----------------------------------------------------------------------------
// joystick_direction_and_button_debounce_unit
// Takes one poll per transaction (tick, optional X/Y sample pair, button
// level) and emits direction and press events. A poll is taken every cycle
// while the event queue has room; it is registered, evaluated, and its
// events (none, one or two) go to a four-entry queue that drives the
// event channel at one event per cycle while the receiver is ready. The
// debounce tick count may be written at any time the unit is idle; its
// reset value is eight.
// ----------------------------------------------------------------------------
module joystick_direction_and_button_debounce_unit
	import jdb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	jdb_in_if.sink      in_chan,
	jdb_out_if.source   out_chan,
	jdb_cfg_if.sink     cfg
);

	in_item_t  item_s1;
	logic      valid_s1;
	logic      fire, space2, accept;
	result_t   result;
	out_item_t out_item;

	assign fire           = valid_s1 && space2;
	assign in_chan.ready  = !valid_s1 || fire;
	assign accept         = in_chan.valid && in_chan.ready;
	assign cfg.ready      = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_chan.ready) begin
			valid_s1 <= in_chan.valid;
		end
	end

	// hold the poll until the queue has room for its events
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{tick: in_chan.tick, sample_valid: in_chan.sample_valid,
				x_sample: in_chan.x_sample, y_sample: in_chan.y_sample,
				button_level: in_chan.button_level};
		end
	end

	jdb_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.result   (result)
	);

	jdb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.result    (result),
		.space2    (space2),
		.out_valid (out_chan.valid),
		.out_ready (out_chan.ready),
		.out_item  (out_item)
	);

	assign out_chan.event_code = out_item.code;
	assign out_chan.last       = out_item.last;

endmodule
